// ===== src/tsc_pkg.sv =====
// Shared types and constants for the Taylor-series sine, cosine and tangent block.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int IFB = 52;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
    localparam int CHUNKS = 4;
    localparam int CHUNK_W = 16;
    localparam int REM_W = 12;
    localparam int NUM_W = REM_W + CHUNK_W;
    localparam int DIV_BITS = 32;
    localparam int LANE_SIN = 0;
    localparam int LANE_COS = 1;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_LIMIT = 1'b1;
    localparam logic [28:0] COS_FLOOR_RST = 29'd1;
    localparam logic [30:0] TAN_LIMIT_RST = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] angle;
    } angle_req_t;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
        logic signed [31:0] tangent;
        logic               tan_saturated;
    } trig_rsp_t;

    typedef struct packed {
        logic        valid;
        logic        aneg;
        logic        apos;
        logic [31:0] rem;
    } red_bus_t;

    typedef struct packed {
        logic            valid;
        logic            aneg;
        logic            apos;
        logic [63:0]     x2;
        logic [1:0][63:0] t;
        logic [1:0][63:0] sum;
    } term_bus_t;

    typedef struct packed {
        logic        valid;
        logic        apos;
        logic [31:0] sine;
        logic [31:0] cosine;
        logic [31:0] cm;
        logic        pole;
        logic        ovf;
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] q;
    } div_bus_t;

endpackage

// ===== src/tsc_stream_if.sv =====
// Valid/ready stream interface carrying one payload of a given type.
`timescale 1ns / 1ps

interface tsc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/tsc_reduce.sv =====
// One compare-and-subtract cell of the angle reduction modulo 2*pi.
`timescale 1ns / 1ps

module tsc_reduce #(
    parameter logic [63:0] STEP = 64'd1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tsc_pkg::red_bus_t  bus_in,
    output tsc_pkg::red_bus_t  bus_out
);

    tsc_pkg::red_bus_t bus_reg;
    tsc_pkg::red_bus_t bus_next;

    always_comb
    begin
        bus_next = bus_in;
        if ({32'd0, bus_in.rem} >= STEP)
        begin
            bus_next.rem = bus_in.rem - STEP[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

// ===== src/tsc_term.sv =====
// One Taylor term cell: multiply by x squared, divide by a constant, accumulate.
`timescale 1ns / 1ps

module tsc_term #(
    parameter int N_IDX = 1,
    parameter int SIN_TERMS = 16,
    parameter int COS_TERMS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  tsc_pkg::term_bus_t  bus_in,
    output tsc_pkg::term_bus_t  bus_out
);

    localparam int STAGES = 2 + 2 * tsc_pkg::CHUNKS;
    localparam int LAST = tsc_pkg::CHUNKS - 1;

    tsc_pkg::term_bus_t pipe_reg [STAGES-1];
    tsc_pkg::term_bus_t out_reg;
    tsc_pkg::term_bus_t out_next;
    logic [63:0] t_new [2];
    logic [63:0] sum_new [2];

    always_comb
    begin
        out_next = pipe_reg[STAGES-2];
        out_next.t[tsc_pkg::LANE_SIN] = t_new[tsc_pkg::LANE_SIN];
        out_next.t[tsc_pkg::LANE_COS] = t_new[tsc_pkg::LANE_COS];
        out_next.sum[tsc_pkg::LANE_SIN] = sum_new[tsc_pkg::LANE_SIN];
        out_next.sum[tsc_pkg::LANE_COS] = sum_new[tsc_pkg::LANE_COS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES - 1; k++)
            begin
                pipe_reg[k] <= '0;
            end
            out_reg <= '0;
        end
        else if (en)
        begin
            pipe_reg[0] <= bus_in;
            for (int k = 1; k < STAGES - 1; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign bus_out = out_reg;

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        localparam int TERMS = (l == tsc_pkg::LANE_SIN) ? SIN_TERMS : COS_TERMS;
        localparam int DIV = (l == tsc_pkg::LANE_SIN) ? (2 * N_IDX) * (2 * N_IDX + 1)
                                                      : (2 * N_IDX - 1) * (2 * N_IDX);
        localparam int LOGD = $clog2(DIV);
        localparam int K = tsc_pkg::NUM_W + LOGD;
        localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);

        if (N_IDX < TERMS)
        begin : g_on
            logic [63:0]  pll_reg, plh_reg, phl_reg, phh_reg;
            logic [63:0]  m_reg;
            logic [127:0] full;
            logic [27:0]  n_reg [tsc_pkg::CHUNKS];
            logic [15:0]  q_reg [tsc_pkg::CHUNKS];
            logic [63:0]  qm_reg [tsc_pkg::CHUNKS];
            logic [63:0]  qacc_reg [tsc_pkg::CHUNKS];
            logic [11:0]  r_reg [tsc_pkg::CHUNKS-1];
            logic [63:0]  rm_reg [tsc_pkg::CHUNKS-1];
            logic [63:0]  racc_reg [tsc_pkg::CHUNKS-1];
            logic [63:0]  q_full;
            logic [63:0]  sum_old;

            assign full = {phh_reg, 64'd0} + {32'd0, plh_reg, 32'd0} + {32'd0, phl_reg, 32'd0}
                        + {64'd0, pll_reg} + (128'd1 << (tsc_pkg::IFB - 1));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pll_reg <= 64'(bus_in.t[l][31:0]) * 64'(bus_in.x2[31:0]);
                    plh_reg <= 64'(bus_in.t[l][31:0]) * 64'(bus_in.x2[63:32]);
                    phl_reg <= 64'(bus_in.t[l][63:32]) * 64'(bus_in.x2[31:0]);
                    phh_reg <= 64'(bus_in.t[l][63:32]) * 64'(bus_in.x2[63:32]);
                    m_reg   <= full[tsc_pkg::IFB+63:tsc_pkg::IFB];
                end
            end

            for (genvar c = 0; c < tsc_pkg::CHUNKS; c++)
            begin : g_chunk
                logic [11:0] r_in;
                logic [63:0] m_in;
                logic [63:0] acc_in;
                logic [27:0] num;
                logic [57:0] prod;

                if (c == 0)
                begin : g_first
                    assign r_in = '0;
                    assign m_in = m_reg;
                    assign acc_in = '0;
                end
                else
                begin : g_next
                    assign r_in = r_reg[c-1];
                    assign m_in = rm_reg[c-1];
                    assign acc_in = racc_reg[c-1];
                end

                assign num = {r_in, m_in[63-16*c -: 16]};
                assign prod = 58'(num) * 58'(RECIP[29:0]);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        n_reg[c]    <= num;
                        q_reg[c]    <= prod[K +: 16];
                        qm_reg[c]   <= m_in;
                        qacc_reg[c] <= acc_in;
                    end
                end

                if (c < LAST)
                begin : g_rem
                    logic [27:0] rprod;
                    logic [27:0] rdiff;

                    assign rprod = 28'(q_reg[c]) * 28'(DIV);
                    assign rdiff = n_reg[c] - rprod;

                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            r_reg[c]    <= rdiff[11:0];
                            rm_reg[c]   <= qm_reg[c];
                            racc_reg[c] <= {qacc_reg[c][47:0], q_reg[c]};
                        end
                    end
                end
            end

            assign q_full = {qacc_reg[LAST][47:0], q_reg[LAST]};
            assign sum_old = pipe_reg[STAGES-2].sum[l];
            assign t_new[l] = q_full;
            assign sum_new[l] = ((N_IDX % 2) == 1) ? (sum_old - q_full) : (sum_old + q_full);
        end
        else
        begin : g_off
            assign t_new[l] = pipe_reg[STAGES-2].t[l];
            assign sum_new[l] = pipe_reg[STAGES-2].sum[l];
        end
    end

endmodule

// ===== src/tsc_div.sv =====
// One restoring-division cell producing one quotient bit of the tangent.
`timescale 1ns / 1ps

module tsc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tsc_pkg::div_bus_t  bus_in,
    output tsc_pkg::div_bus_t  bus_out
);

    tsc_pkg::div_bus_t bus_reg;
    tsc_pkg::div_bus_t bus_next;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        shifted = {bus_in.rem, bus_in.num[31]};
        diff = shifted - {1'b0, bus_in.cm};
        ge = shifted >= {1'b0, bus_in.cm};
        bus_next = bus_in;
        bus_next.rem = ge ? diff[31:0] : shifted[31:0];
        bus_next.num = {bus_in.num[30:0], 1'b0};
        bus_next.q = {bus_in.q[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

// ===== src/taylor_sin_cos_tan.sv =====
// The angle reduction has QB reduction cells (1 at FRAC_BITS = 28).
// Throughput: one request per cycle while the output is not stalled; each Taylor term
// cell is a 10-stage pipeline and the tangent divider resolves one quotient bit per cell
// over 32 cells.
// The whole pipeline holds while a result waits at the output register.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps

module taylor_sin_cos_tan #(
    parameter int SIN_TERMS = 16,
    parameter int COS_TERMS = 10,
    parameter int FRAC_BITS = 28
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tsc_stream_if.sink                         req,
    tsc_stream_if.source                       rsp,
    input  logic                               cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SH = tsc_pkg::IFB - FRAC_BITS;
    localparam logic [63:0] TWO_PI_FIX =
        (tsc_pkg::TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] QUOT_MAX = 64'h8000_0000 / TWO_PI_FIX;
    localparam int QB = (QUOT_MAX == 64'd0) ? 1 : $clog2(QUOT_MAX + 64'd1);
    localparam int NT = ((SIN_TERMS > COS_TERMS) ? SIN_TERMS : COS_TERMS) - 1;

    logic [28:0] cos_floor_reg;
    logic [30:0] tan_limit_reg;

    logic adv;

    tsc_pkg::red_bus_t  in_reg;
    tsc_pkg::red_bus_t  red_bus [QB+1];
    tsc_pkg::red_bus_t  x1_reg;
    logic [63:0]        xll_reg, xlh_reg, xhl_reg, xhh_reg;
    logic [63:0]        xm_in;
    logic [63:0]        xm1;
    logic [127:0]       xfull;
    tsc_pkg::term_bus_t term_bus [NT+1];
    tsc_pkg::term_bus_t term0_reg;

    logic        f1_valid_reg;
    logic        f1_apos_reg;
    logic [31:0] f1_sine_reg;
    logic [31:0] f1_cosine_reg;

    tsc_pkg::div_bus_t div_bus [tsc_pkg::DIV_BITS+1];
    tsc_pkg::div_bus_t div0_reg;
    tsc_pkg::div_bus_t div0_next;
    logic [31:0]       sm;
    logic [31:0]       cm;

    logic               rsp_valid_reg;
    tsc_pkg::trig_rsp_t rsp_data_reg;
    tsc_pkg::trig_rsp_t rsp_data_next;
    logic [31:0]        raw;
    logic [31:0]        mag;

    function automatic logic [31:0] to_fix(input logic [63:0] v, input logic neg_in);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] nr;
        logic        neg;
        neg = neg_in ^ v[63];
        m = v[63] ? (~v + 64'd1) : v;
        r = (m + (64'd1 << (SH - 1))) >> SH;
        nr = 64'd0 - r;
        if (neg)
        begin
            to_fix = (r > 64'h8000_0000) ? 32'h8000_0000 : nr[31:0];
        end
        else
        begin
            to_fix = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
    endfunction

    assign adv = !rsp_valid_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_floor_reg <= tsc_pkg::COS_FLOOR_RST;
            tan_limit_reg <= tsc_pkg::TAN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tsc_pkg::CFG_COS_FLOOR: cos_floor_reg <= cfg_wdata[28:0];
                tsc_pkg::CFG_TAN_LIMIT: tan_limit_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign raw = req.data.angle;
    assign mag = raw[31] ? (~raw + 32'd1) : raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else if (adv)
        begin
            in_reg.valid <= req.valid;
            in_reg.aneg <= raw[31];
            in_reg.apos <= !raw[31] && (raw != 32'd0);
            in_reg.rem <= mag;
        end
    end

    assign red_bus[0] = in_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_reduce
        tsc_reduce #(
            .STEP (TWO_PI_FIX << (QB - 1 - k))
        ) u_reduce (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .bus_in  (red_bus[k]),
            .bus_out (red_bus[k+1])
        );
    end

    assign xm_in = 64'(red_bus[QB].rem) << SH;
    assign xm1 = 64'(x1_reg.rem) << SH;
    assign xfull = {xhh_reg, 64'd0} + {32'd0, xlh_reg, 32'd0} + {32'd0, xhl_reg, 32'd0}
                 + {64'd0, xll_reg} + (128'd1 << (tsc_pkg::IFB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            term0_reg <= '0;
        end
        else if (adv)
        begin
            x1_reg <= red_bus[QB];
            term0_reg.valid <= x1_reg.valid;
            term0_reg.aneg <= x1_reg.aneg;
            term0_reg.apos <= x1_reg.apos;
            term0_reg.x2 <= xfull[tsc_pkg::IFB+63:tsc_pkg::IFB];
            term0_reg.t[tsc_pkg::LANE_SIN] <= xm1;
            term0_reg.sum[tsc_pkg::LANE_SIN] <= xm1;
            term0_reg.t[tsc_pkg::LANE_COS] <= 64'd1 << tsc_pkg::IFB;
            term0_reg.sum[tsc_pkg::LANE_COS] <= 64'd1 << tsc_pkg::IFB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xll_reg <= 64'(xm_in[31:0]) * 64'(xm_in[31:0]);
            xlh_reg <= 64'(xm_in[31:0]) * 64'(xm_in[63:32]);
            xhl_reg <= 64'(xm_in[63:32]) * 64'(xm_in[31:0]);
            xhh_reg <= 64'(xm_in[63:32]) * 64'(xm_in[63:32]);
        end
    end

    assign term_bus[0] = term0_reg;

    for (genvar n = 0; n < NT; n++)
    begin : g_term
        tsc_term #(
            .N_IDX     (n + 1),
            .SIN_TERMS (SIN_TERMS),
            .COS_TERMS (COS_TERMS)
        ) u_term (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .bus_in  (term_bus[n]),
            .bus_out (term_bus[n+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f1_apos_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= term_bus[NT].valid;
            f1_apos_reg <= term_bus[NT].apos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_sine_reg <= to_fix(term_bus[NT].sum[tsc_pkg::LANE_SIN], term_bus[NT].aneg);
            f1_cosine_reg <= to_fix(term_bus[NT].sum[tsc_pkg::LANE_COS], 1'b0);
        end
    end

    assign sm = f1_sine_reg[31] ? (~f1_sine_reg + 32'd1) : f1_sine_reg;
    assign cm = f1_cosine_reg[31] ? (~f1_cosine_reg + 32'd1) : f1_cosine_reg;

    always_comb
    begin
        div0_next.valid = f1_valid_reg;
        div0_next.apos = f1_apos_reg;
        div0_next.sine = f1_sine_reg;
        div0_next.cosine = f1_cosine_reg;
        div0_next.cm = cm;
        div0_next.pole = (cm == 32'd0) || (cm < 32'(cos_floor_reg));
        div0_next.ovf = {16'd0, sm[31:16]} >= cm;
        div0_next.rem = {16'd0, sm[31:16]};
        div0_next.num = {sm[15:0], 16'd0};
        div0_next.q = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div0_reg <= '0;
        end
        else if (adv)
        begin
            div0_reg <= div0_next;
        end
    end

    assign div_bus[0] = div0_reg;

    for (genvar b = 0; b < tsc_pkg::DIV_BITS; b++)
    begin : g_div
        tsc_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .bus_in  (div_bus[b]),
            .bus_out (div_bus[b+1])
        );
    end

    always_comb
    begin
        logic [31:0] q;
        logic [31:0] lim;
        logic        qneg;
        logic        over;
        logic        sat;
        q = div_bus[tsc_pkg::DIV_BITS].q;
        lim = {1'b0, tan_limit_reg};
        qneg = (div_bus[tsc_pkg::DIV_BITS].sine[31] ^ div_bus[tsc_pkg::DIV_BITS].cosine[31])
             && (q != 32'd0);
        over = qneg ? (q > 32'h8000_0000) : (q > 32'h7FFF_FFFF);
        sat = div_bus[tsc_pkg::DIV_BITS].pole || div_bus[tsc_pkg::DIV_BITS].ovf || over;
        rsp_data_next.sine = div_bus[tsc_pkg::DIV_BITS].sine;
        rsp_data_next.cosine = div_bus[tsc_pkg::DIV_BITS].cosine;
        if (sat)
        begin
            rsp_data_next.tangent = div_bus[tsc_pkg::DIV_BITS].apos ? lim : (~lim + 32'd1);
        end
        else
        begin
            rsp_data_next.tangent = qneg ? (~q + 32'd1) : q;
        end
        rsp_data_next.tan_saturated = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= div_bus[tsc_pkg::DIV_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = rsp_data_reg;

endmodule

// ===== src/tsc_checker.sv =====
// Port-level checker for the sine, cosine and tangent block, with its bind statement.
`timescale 1ns / 1ps

module tsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] sine,
    input logic [31:0] cosine,
    input logic [31:0] tangent,
    input logic        tan_saturated
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({sine, cosine, tangent, tan_saturated}))
        else $error("Result changed while it was stalled.");

    a_req_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> req_ready == (!rsp_valid || rsp_ready))
        else $error("Request ready does not follow the output stall.");

    a_pole: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && cosine == 32'd0 |-> tan_saturated)
        else $error("Zero cosine gave an unsaturated tangent.");

    a_tan_sign: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !tan_saturated && tangent != 32'd0 |-> tangent[31] == (sine[31] ^ cosine[31]))
        else $error("Tangent sign disagrees with sine and cosine.");

endmodule

bind taylor_sin_cos_tan tsc_checker u_tsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .sine          (rsp.data.sine),
    .cosine        (rsp.data.cosine),
    .tangent       (rsp.data.tangent),
    .tan_saturated (rsp.data.tan_saturated)
);

// ===== test/tsc_checker.sv =====
// Checker that predicts sine, cosine and tangent for each request and compares the results.
`timescale 1ns / 1ps

module tsc_tb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  tsc_pkg::angle_req_t            req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  tsc_pkg::trig_rsp_t             rsp_data,
    input  logic                           cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             outstanding,
    output int                             mismatches
);

    localparam int FRAC = 28;
    localparam logic [63:0] TWO_PI_FIX =
        (tsc_pkg::TWO_PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);

    logic [28:0]        cos_floor;
    logic [30:0]        tan_limit;
    tsc_pkg::trig_rsp_t trig_q[$];

    function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (tsc_pkg::IFB - 1));
        return p[tsc_pkg::IFB +: 64];
    endfunction

    function automatic logic [31:0] round_out(longint v, bit neg);
        logic [63:0] m;
        if (v < 0)
        begin
            m = -v;
            neg = !neg;
        end
        else
        begin
            m = v;
        end
        m = (m + (64'd1 << (tsc_pkg::IFB - FRAC - 1))) >> (tsc_pkg::IFB - FRAC);
        if (neg)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            m = -m;
            return m[31:0];
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic tsc_pkg::trig_rsp_t predict_trig(logic [31:0] raw);
        tsc_pkg::trig_rsp_t res;
        bit          aneg;
        bit          sneg;
        bit          cneg;
        bit          qneg;
        bit          sat;
        logic [63:0] mag;
        logic [63:0] xm;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sm;
        logic [63:0] cm;
        logic [63:0] q;
        longint      ssum;
        longint      csum;
        logic [31:0] s_out;
        logic [31:0] c_out;
        logic [31:0] tan_out;
        aneg = raw[31];
        mag = aneg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        xm = (mag % TWO_PI_FIX) << (tsc_pkg::IFB - FRAC);
        x2 = mul_rnd(xm, xm);
        t = xm;
        ssum = t;
        for (int n = 1; n < 16; n++)
        begin
            t = mul_rnd(t, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                ssum = ssum - longint'(t);
            else
                ssum = ssum + longint'(t);
        end
        t = 64'd1 << tsc_pkg::IFB;
        csum = t;
        for (int n = 1; n < 10; n++)
        begin
            t = mul_rnd(t, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                csum = csum - longint'(t);
            else
                csum = csum + longint'(t);
        end
        s_out = round_out(ssum, aneg);
        c_out = round_out(csum, 1'b0);
        sneg = s_out[31];
        cneg = c_out[31];
        sm = sneg ? (64'h1_0000_0000 - {32'd0, s_out}) : {32'd0, s_out};
        cm = cneg ? (64'h1_0000_0000 - {32'd0, c_out}) : {32'd0, c_out};
        sat = 1'b0;
        tan_out = '0;
        if (cm == 0 || cm < {35'd0, cos_floor})
        begin
            sat = 1'b1;
        end
        else
        begin
            q = (sm << 16) / cm;
            qneg = (sneg != cneg) && q != 0;
            if ((qneg && q > 64'h8000_0000) || (!qneg && q > 64'h7FFF_FFFF))
                sat = 1'b1;
            else
                tan_out = qneg ? 32'(-q) : q[31:0];
        end
        if (sat)
            tan_out = (!aneg && raw != 0) ? {1'b0, tan_limit} : -{1'b0, tan_limit};
        res.sine = s_out;
        res.cosine = c_out;
        res.tangent = tan_out;
        res.tan_saturated = sat;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tsc_pkg::trig_rsp_t exp_rsp;
        if (!rst_n)
        begin
            cos_floor <= tsc_pkg::COS_FLOOR_RST;
            tan_limit <= tsc_pkg::TAN_LIMIT_RST;
            trig_q.delete();
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == tsc_pkg::CFG_COS_FLOOR)
                    cos_floor <= cfg_wdata[28:0];
                else if (cfg_idx == tsc_pkg::CFG_TAN_LIMIT)
                    tan_limit <= cfg_wdata[30:0];
            end
            if (req_valid && req_ready)
                trig_q.push_back(predict_trig(req_data.angle));
            if (rsp_valid && rsp_ready)
            begin
                if (trig_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result %h", $realtime, rsp_data);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_rsp = trig_q.pop_front();
                    if (exp_rsp !== rsp_data)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch sin %h/%h cos %h/%h tan %h/%h sat %b/%b",
                                $realtime, exp_rsp.sine, rsp_data.sine, exp_rsp.cosine,
                                rsp_data.cosine, exp_rsp.tangent, rsp_data.tangent,
                                exp_rsp.tan_saturated, rsp_data.tan_saturated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= trig_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives angle requests and register writes, and gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam logic [31:0] TWO_PI_FIX = 32'd1686629713;
    localparam logic [31:0] HALF_PI = 32'd421657428;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [tsc_pkg::CFG_IDX_W-1:0] cfg_idx = tsc_pkg::CFG_COS_FLOOR;
    logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    int outstanding;
    int mismatches;
    int idle_cycles = 0;
    bit no_gaps = 1'b0;

    tsc_stream_if #(.T(tsc_pkg::angle_req_t)) req_if();
    tsc_stream_if #(.T(tsc_pkg::trig_rsp_t)) rsp_if();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    taylor_sin_cos_tan u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if.sink),
        .rsp       (rsp_if.source),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    tsc_tb_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_if.valid),
        .req_ready   (req_if.ready),
        .req_data    (req_if.data),
        .rsp_valid   (rsp_if.valid),
        .rsp_ready   (rsp_if.ready),
        .rsp_data    (rsp_if.data),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int stall;
        bit hs;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
                do
                begin
                    @(negedge clk);
                    hs = rsp_if.valid;
                    if (!hs)
                        @(posedge clk);
                end
                while (!hs);
            end
        end
    end

    task automatic send_angle(logic [31:0] a);
        int gap;
        bit hs;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data.angle <= a;
        do
        begin
            @(negedge clk);
            hs = req_if.ready;
            @(posedge clk);
        end
        while (!hs);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_regs(logic [28:0] floor_val, logic [30:0] limit_val);
        cfg_we <= 1'b1;
        cfg_idx <= tsc_pkg::CFG_COS_FLOOR;
        cfg_wdata <= {2'b00, floor_val};
        @(posedge clk);
        cfg_idx <= tsc_pkg::CFG_TAN_LIMIT;
        cfg_wdata <= limit_val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_angle();
        logic [31:0] k;
        logic [31:0] a;
        int sel;
        sel = $urandom_range(0, 9);
        k = $urandom_range(0, 4);
        case (sel) inside
            [0:3]:   a = $urandom;
            [4:5]:   a = $urandom_range(0, 32'h0FFF_FFFF);
            [6:7]:   a = HALF_PI * (2 * $urandom_range(0, 9) + 1) + $urandom_range(0, 200) - 100;
            8:       a = TWO_PI_FIX * k;
            default: a = {{20{1'b0}}, 12'($urandom)};
        endcase
        if ($urandom_range(0, 1))
            a = -a;
        return a;
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(29'd1, 31'h7FFF_FFFF);
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, TWO_PI_FIX, -TWO_PI_FIX, 2 * TWO_PI_FIX,
                     TWO_PI_FIX - 1, HALF_PI, -HALF_PI, 2 * HALF_PI, 3 * HALF_PI,
                     -3 * HALF_PI, HALF_PI + 1, HALF_PI - 1, 32'h1000_0000,
                     32'hF000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (directed[i])
            send_angle(directed[i]);
        wait_drained();
        write_regs(29'h1000_0000, 31'd0);
        foreach (directed[i])
            send_angle(directed[i]);
        wait_drained();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_regs(29'd0, 31'h7FFF_FFFF);
                1: write_regs(29'd1, 31'($urandom));
                2: write_regs(29'h1000_0000, 31'h7FFF_FFFF);
                3: write_regs(29'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)));
                default: write_regs(29'($urandom_range(0, 29'h1000_0000)), 31'($urandom));
            endcase
            for (int i = 0; i < 300; i++)
            begin
                if (i % 60 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_angle(random_angle());
            end
            no_gaps = 1'b0;
            wait_drained();
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tsc_pkg.sv
src/tsc_stream_if.sv
src/tsc_reduce.sv
src/tsc_term.sv
src/tsc_div.sv
src/taylor_sin_cos_tan.sv
src/tsc_checker.sv
test/tsc_checker.sv
test/tb.sv
